@@ rtl/ircfs_pkg.sv @@
// shared types and constants for the irc message field splitter
package ircfs_pkg;

  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_AT    = 8'h40;

  localparam int          CountW       = 4;
  localparam logic [CountW-1:0] MaxMiddleReset = 4'd14;

  typedef enum logic [2:0] {
    CL_DELIM   = 3'd0,
    CL_NICK    = 3'd1,
    CL_HOST    = 3'd2,
    CL_COMMAND = 3'd3,
    CL_MIDDLE  = 3'd4,
    CL_TRAIL   = 3'd5
  } field_class_t;

  typedef enum logic [6:0] {
    PH_START       = 7'b0000001,
    PH_PFX_FIRST   = 7'b0000010,
    PH_PFX_IN      = 7'b0000100,
    PH_GAP         = 7'b0001000,
    PH_WORD        = 7'b0010000,
    PH_TRAIL_FIRST = 7'b0100000,
    PH_TRAIL       = 7'b1000000
  } phase_t;

  typedef struct packed {
    phase_t            phase;
    logic [CountW-1:0] middle_count;
    logic              host_begun;
    logic              command_seen;
  } parse_state_t;

  typedef struct packed {
    field_class_t      field_class;
    logic [CountW-1:0] param_number;
    logic              field_start;
    logic              message_valid;
  } byte_tag_t;

endpackage

@@ rtl/ircfs_if.sv @@
// channel interfaces for message bytes and tagged results
interface ircfs_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink (input valid, input data_byte, input end_of_message, output ready);
endinterface

interface ircfs_tag_if;
  logic       valid;
  logic       ready;
  logic [7:0] echo_byte;
  logic [2:0] field_class;
  logic [3:0] param_number;
  logic       field_start;
  logic       message_valid;
  logic       last_of_message;

  modport source (output valid, output echo_byte, output field_class, output param_number,
                  output field_start, output message_valid, output last_of_message,
                  input ready);
  modport sink (input valid, input echo_byte, input field_class, input param_number,
                input field_start, input message_valid, input last_of_message,
                output ready);
endinterface

@@ rtl/ircfs_classify.sv @@
// per-byte field classification and next parser state
module ircfs_classify
  import ircfs_pkg::*;
(
  input  parse_state_t      cur,
  input  logic [7:0]        data_byte,
  input  logic              end_of_message,
  input  logic [CountW-1:0] max_middle,
  output parse_state_t      nxt,
  output byte_tag_t         tag
);

  logic [CountW-1:0] count_inc;
  logic              is_colon;
  logic              is_space;
  logic              is_sep;

  assign count_inc = cur.middle_count + 1'b1;
  assign is_colon  = (data_byte == CH_COLON);
  assign is_space  = (data_byte == CH_SPACE);
  assign is_sep    = (data_byte == CH_BANG) || ((data_byte == CH_AT) && !cur.host_begun);

  always_comb begin
    nxt               = cur;
    tag.field_class   = CL_DELIM;
    tag.param_number  = '0;
    tag.field_start   = 1'b0;
    case (cur.phase)
      PH_START: begin
        if (is_colon) begin
          nxt.phase = PH_PFX_FIRST;
        end else if (is_space) begin
          nxt.phase = PH_GAP;
        end else begin
          tag.field_class  = CL_COMMAND;
          tag.field_start  = 1'b1;
          nxt.command_seen = 1'b1;
          nxt.phase        = PH_WORD;
        end
      end
      PH_PFX_FIRST, PH_PFX_IN: begin
        if (is_sep) begin
          nxt.host_begun = 1'b1;
          nxt.phase      = PH_PFX_FIRST;
        end else if (is_space) begin
          nxt.phase = PH_GAP;
        end else begin
          tag.field_class = cur.host_begun ? CL_HOST : CL_NICK;
          tag.field_start = (cur.phase == PH_PFX_FIRST);
          nxt.phase       = PH_PFX_IN;
        end
      end
      PH_GAP: begin
        if (is_space) begin
          nxt.phase = PH_GAP;
        end else if (!cur.command_seen) begin
          tag.field_class  = CL_COMMAND;
          tag.field_start  = 1'b1;
          nxt.command_seen = 1'b1;
          nxt.phase        = PH_WORD;
        end else if (is_colon) begin
          nxt.phase = PH_TRAIL_FIRST;
        end else if (cur.middle_count >= max_middle) begin
          tag.field_class = CL_TRAIL;
          tag.field_start = 1'b1;
          nxt.phase       = PH_TRAIL;
        end else begin
          nxt.middle_count = count_inc;
          tag.field_class  = CL_MIDDLE;
          tag.param_number = count_inc;
          tag.field_start  = 1'b1;
          nxt.phase        = PH_WORD;
        end
      end
      PH_WORD: begin
        if (is_space) begin
          nxt.phase = PH_GAP;
        end else if (cur.middle_count == '0) begin
          tag.field_class = CL_COMMAND;
        end else begin
          tag.field_class  = CL_MIDDLE;
          tag.param_number = cur.middle_count;
        end
      end
      PH_TRAIL_FIRST: begin
        tag.field_class = CL_TRAIL;
        tag.field_start = 1'b1;
        nxt.phase       = PH_TRAIL;
      end
      default: begin
        tag.field_class = CL_TRAIL;
        nxt.phase       = PH_TRAIL;
      end
    endcase

    tag.message_valid = end_of_message && nxt.command_seen;

    // last byte closes the message, parser starts clean
    if (end_of_message) begin
      nxt.phase        = PH_START;
      nxt.middle_count = '0;
      nxt.host_begun   = 1'b0;
      nxt.command_seen = 1'b0;
    end
  end

endmodule

@@ rtl/irc_message_field_splitter.sv @@
// top level of the irc message field splitter
//
// Takes one raw IRC message byte per request on in_ch (data_byte plus an
// end_of_message flag on the final byte) and returns one tagged result per
// byte on out_ch: the byte itself, its field class (delimiter, prefix nick,
// host info, command, middle, trailing), the middle parameter number, a
// field start flag, and on the last byte message_valid and last_of_message.
// cfg_we/cfg_wdata set how many middle parameters are allowed before the
// rest of the message becomes trailing; write it only while idle.
// Each result is registered after the single classification step between
// the parser state register and the result register; throughput is one
// byte per cycle while out_ch.ready does not hold the result register.
// The result register holds its request while out_ch.ready is low; a new
// byte is still taken in the same cycle the held result leaves, so stalls
// on the output only hold the input for as long as they last.
// Reset clears the parser to the start of a message, empties the result
// register and sets the middle parameter limit to fourteen.
module irc_message_field_splitter
  import ircfs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  ircfs_byte_if.sink        in_ch,
  ircfs_tag_if.source       out_ch,
  input  logic              cfg_we,
  input  logic [CountW-1:0] cfg_wdata
);

  parse_state_t      state_r, state_nxt;
  byte_tag_t         tag_nxt, tag_r;
  logic [CountW-1:0] max_middle_r;
  logic              out_valid_r;
  logic [7:0]        echo_r;
  logic              last_r;
  logic              accept;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  ircfs_classify u_classify (
    .cur            (state_r),
    .data_byte      (in_ch.data_byte),
    .end_of_message (in_ch.end_of_message),
    .max_middle     (max_middle_r),
    .nxt            (state_nxt),
    .tag            (tag_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase        <= PH_START;
      state_r.middle_count <= '0;
      state_r.host_begun   <= 1'b0;
      state_r.command_seen <= 1'b0;
      max_middle_r         <= MaxMiddleReset;
      out_valid_r          <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_middle_r <= cfg_wdata;
      end
      if (accept) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tag_r  <= tag_nxt;
      echo_r <= in_ch.data_byte;
      last_r <= in_ch.end_of_message;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.echo_byte       = echo_r;
  assign out_ch.field_class     = tag_r.field_class;
  assign out_ch.param_number    = tag_r.param_number;
  assign out_ch.field_start     = tag_r.field_start;
  assign out_ch.message_valid   = tag_r.message_valid;
  assign out_ch.last_of_message = last_r;

endmodule
